// ----- src/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit disable condition
`define SBDE_ASSERT_DIS(label, clk, dis, prop, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (prop)) \
        else $error(msg);

// clocked assertion held off while the active-low reset is asserted
`define SBDE_ASSERT(label, clk, rst_n, prop, msg) \
    `SBDE_ASSERT_DIS(label, clk, !(rst_n), prop, msg)

`endif

// ----- src/sbde_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbde_pkg;

    localparam int unsigned DEF_LANES      = 4;
    localparam int unsigned DEF_WORD_WIDTH = 64;
    // source and result lanes present on the ports
    localparam int unsigned IN_LANES       = 4;
    localparam int unsigned PORT_W         = 64;
    localparam int unsigned Q_DEPTH        = 2;

    typedef enum logic {
        OP_PUSH    = 1'b0,
        OP_DEPOSIT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DEPOSITED = 2'd0,
        ST_ACCEPTED  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // queue entry: op, popcount, per-bit source index, mask, source words
    function automatic int unsigned q_width(input int unsigned w);
        return 1 + $clog2(w + 1) + w * $clog2(w) + w + IN_LANES * w;
    endfunction

endpackage

`default_nettype wire

// ----- src/sbde_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sbde_in_if import sbde_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [PORT_W-1:0] mask;
    logic [PORT_W-1:0] src_lane0;
    logic [PORT_W-1:0] src_lane1;
    logic [PORT_W-1:0] src_lane2;
    logic [PORT_W-1:0] src_lane3;

    modport source (
        output valid, func, mask, src_lane0, src_lane1, src_lane2, src_lane3,
        input  ready
    );
    modport sink (
        input  valid, func, mask, src_lane0, src_lane1, src_lane2, src_lane3,
        output ready
    );
endinterface

interface sbde_out_if import sbde_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PORT_W-1:0] out_lane0;
    logic [PORT_W-1:0] out_lane1;
    logic [PORT_W-1:0] out_lane2;
    logic [PORT_W-1:0] out_lane3;

    modport source (
        output valid, status, out_lane0, out_lane1, out_lane2, out_lane3,
        input  ready
    );
    modport sink (
        input  valid, status, out_lane0, out_lane1, out_lane2, out_lane3,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/sbde_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbde_front import sbde_pkg::*; #(
    parameter int unsigned WORD_WIDTH = DEF_WORD_WIDTH
) (
    sbde_in_if.sink                          i_item,
    output logic                             o_valid,
    output logic [q_width(WORD_WIDTH)-1:0]   o_data,
    input  logic                             i_ready
);

    localparam int unsigned W       = WORD_WIDTH;
    localparam int unsigned IW      = $clog2(W);
    localparam int unsigned PCW     = $clog2(W + 1);
    localparam int unsigned LV      = $clog2(W);
    localparam int unsigned MASK_LO = IN_LANES * W;
    localparam int unsigned IDX_LO  = MASK_LO + W;
    localparam int unsigned PC_LO   = IDX_LO + W * IW;
    localparam int unsigned OP_BIT  = PC_LO + PCW;

    logic [W-1:0]      mask_w;
    logic [PORT_W-1:0] src_in [IN_LANES];
    logic [PCW-1:0]    scan   [LV+1][W];
    logic [IW-1:0]     idx    [W];
    t_op               op;

    assign mask_w    = i_item.mask[W-1:0];
    assign src_in[0] = i_item.src_lane0;
    assign src_in[1] = i_item.src_lane1;
    assign src_in[2] = i_item.src_lane2;
    assign src_in[3] = i_item.src_lane3;
    assign op        = i_item.func ? OP_DEPOSIT : OP_PUSH;

    // inclusive prefix popcount of the mask, log-step scan
    for (genvar b = 0; b < W; b++) begin : g_seed
        assign scan[0][b] = PCW'(mask_w[b]);
    end

    for (genvar k = 0; k < LV; k++) begin : g_lvl
        for (genvar b = 0; b < W; b++) begin : g_bit
            if (b >= (1 << k)) begin : g_add
                assign scan[k+1][b] = scan[k][b] + scan[k][b - (1 << k)];
            end else begin : g_pass
                assign scan[k+1][b] = scan[k][b];
            end
        end
    end

    // source bit index feeding each mask position
    for (genvar b = 0; b < W; b++) begin : g_idx
        assign idx[b] = IW'(scan[LV][b] - PCW'(mask_w[b]));
    end

    always_comb begin
        o_data = '0;
        o_data[OP_BIT] = (op == OP_DEPOSIT);
        o_data[PC_LO +: PCW] = scan[LV][W-1];
        for (int b = 0; b < W; b++) begin
            o_data[IDX_LO + b * IW +: IW] = idx[b];
        end
        o_data[MASK_LO +: W] = mask_w;
        for (int l = 0; l < IN_LANES; l++) begin
            o_data[l * W +: W] = src_in[l][W-1:0];
        end
    end

    assign o_valid      = i_item.valid;
    assign i_item.ready = i_ready;

endmodule

`default_nettype wire

// ----- src/sbde_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbde_queue import sbde_pkg::*; #(
    parameter int unsigned DATA_W = q_width(DEF_WORD_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output logic [DATA_W-1:0] o_pop_data,
    input  logic              i_pop_ready,
    output t_q_stat           o_stat
);

    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_stat.full  = !o_push_ready;
    assign o_stat.empty = !o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/sbde_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbde_back import sbde_pkg::*; #(
    parameter int unsigned LANES      = DEF_LANES,
    parameter int unsigned WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [q_width(WORD_WIDTH)-1:0]         i_data,
    output logic                                   o_ready,
    sbde_out_if.source                             o_result,
    output logic [$clog2(2*WORD_WIDTH+1)-1:0]      o_fill
);

    localparam int unsigned W       = WORD_WIDTH;
    localparam int unsigned DW      = 2 * W;
    localparam int unsigned IW      = $clog2(W);
    localparam int unsigned PCW     = $clog2(W + 1);
    localparam int unsigned FW      = $clog2(DW + 1);
    localparam int unsigned MASK_LO = IN_LANES * W;
    localparam int unsigned IDX_LO  = MASK_LO + W;
    localparam int unsigned PC_LO   = IDX_LO + W * IW;
    localparam int unsigned OP_BIT  = PC_LO + PCW;

    // per-lane bit buffer, low word read first
    logic [W-1:0]  r_lo [LANES], n_lo [LANES];
    logic [W-1:0]  r_hi [LANES], n_hi [LANES];
    logic [FW-1:0] r_fill, n_fill;
    logic          r_out_valid, n_out_valid;
    t_status       r_status, n_status;
    logic [W-1:0]  r_out [IN_LANES], n_out [IN_LANES];

    t_op           op;
    logic [PCW-1:0] pc;
    logic [W-1:0]  mask;
    logic [IW-1:0] idx [W];
    logic [W-1:0]  src [IN_LANES];
    logic [DW-1:0] pushed  [LANES];
    logic [DW-1:0] dropped [LANES];
    logic [W-1:0]  dep     [LANES];
    logic [W-1:0]  dep_out [IN_LANES];
    logic          take;

    assign op   = t_op'(i_data[OP_BIT]);
    assign pc   = i_data[PC_LO +: PCW];
    assign mask = i_data[MASK_LO +: W];

    for (genvar b = 0; b < W; b++) begin : g_idx
        assign idx[b] = i_data[IDX_LO + b * IW +: IW];
    end

    for (genvar l = 0; l < IN_LANES; l++) begin : g_src
        assign src[l] = i_data[l * W +: W];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [DW-1:0] cur;
        logic [DW-1:0] ext_src;
        logic [W-1:0]  dep_l;

        assign cur = {r_hi[l], r_lo[l]};
        if (l < IN_LANES) begin : g_in
            assign ext_src = DW'(src[l]);
        end else begin : g_zero
            assign ext_src = '0;
        end
        // bits above the fill level are zero, so an or appends
        assign pushed[l]  = cur | (ext_src << r_fill);
        assign dropped[l] = cur >> pc;

        always_comb begin
            for (int b = 0; b < W; b++) begin
                dep_l[b] = mask[b] & r_lo[l][idx[b]];
            end
        end
        assign dep[l] = dep_l;
    end

    for (genvar o = 0; o < IN_LANES; o++) begin : g_rep
        if (o < LANES) begin : g_live
            assign dep_out[o] = dep[o];
        end else begin : g_dead
            assign dep_out[o] = '0;
        end
    end

    assign o_ready = !r_out_valid || o_result.ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_out_valid = r_out_valid && !o_result.ready;
        n_status    = r_status;
        n_out       = r_out;
        n_fill      = r_fill;
        n_lo        = r_lo;
        n_hi        = r_hi;
        if (take) begin
            n_out_valid = 1'b1;
            for (int o = 0; o < IN_LANES; o++) begin
                n_out[o] = '0;
            end
            unique case (op)
                OP_PUSH: begin
                    if (r_fill > FW'(W)) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_status = ST_ACCEPTED;
                        n_fill   = r_fill + FW'(W);
                        for (int l = 0; l < LANES; l++) begin
                            n_lo[l] = pushed[l][W-1:0];
                            n_hi[l] = pushed[l][DW-1:W];
                        end
                    end
                end
                OP_DEPOSIT: begin
                    if (r_fill < FW'(pc)) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_status = ST_DEPOSITED;
                        n_fill   = r_fill - FW'(pc);
                        n_out    = dep_out;
                        for (int l = 0; l < LANES; l++) begin
                            n_lo[l] = dropped[l][W-1:0];
                            n_hi[l] = dropped[l][DW-1:W];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            for (int l = 0; l < LANES; l++) begin
                r_lo[l] <= '0;
                r_hi[l] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.status    = r_status;
    assign o_result.out_lane0 = PORT_W'(r_out[0]);
    assign o_result.out_lane1 = PORT_W'(r_out[1]);
    assign o_result.out_lane2 = PORT_W'(r_out[2]);
    assign o_result.out_lane3 = PORT_W'(r_out[3]);
    assign o_fill             = r_fill;

endmodule

`default_nettype wire

// ----- src/stream_bit_deposit_expander.sv -----
// Four-lane bit deposit expander: a push item appends one source word per lane to a two-word
// bit buffer per lane (refused with overflow status when more than one word is still unread),
// and a deposit item scatters the oldest popcount(mask) buffered bits of each lane into the set
// positions of the shared mask, lowest bit first, then drops them (refused with underflow
// status when too few bits are buffered). Every item gives exactly one result. The front stage
// decodes the item and works out the prefix popcount of the mask, a two-entry queue decouples
// it from the back stage, which holds the buffers and the shared fill count and registers the
// result. Sustained rate is one item per clock while results are taken: the only state carried
// from item to item is the fill count and buffer update in the back stage. With the queue empty,
// an accepted item is written into the queue and then taken by the back stage, which registers
// the result; the queue plus the output register keep the input side accepting for two more
// items while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stream_bit_deposit_expander import sbde_pkg::*; #(
    parameter int unsigned LANES      = DEF_LANES,
    parameter int unsigned WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbde_in_if.sink    i_item,
    sbde_out_if.source o_result
);

    localparam int unsigned QW = q_width(WORD_WIDTH);
    localparam int unsigned FW = $clog2(2 * WORD_WIDTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(2 * WORD_WIDTH);

    // front to queue
    logic          f_valid;
    logic [QW-1:0] f_data;
    logic          f_ready;

    // queue to back
    logic          q_valid;
    logic [QW-1:0] q_data;
    logic          q_ready;
    t_q_stat       q_stat;

    logic [FW-1:0] back_fill;
    logic          back_take;

    // decode and mask prefix count, no state
    sbde_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_data  (f_data),
        .i_ready (f_ready)
    );

    // short decoupling queue between decode and execute
    sbde_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_data  (f_data),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_data   (q_data),
        .i_pop_ready  (q_ready),
        .o_stat       (q_stat)
    );

    // bit buffers, fill count and registered result
    sbde_back #(
        .LANES      (LANES),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_data   (q_data),
        .o_ready  (q_ready),
        .o_result (o_result),
        .o_fill   (back_fill)
    );

    assign back_take = q_valid && q_ready;

    // fill count only moves when the back stage takes an item
    `SBDE_ASSERT(a_fill_hold, i_clk, i_rst_n, !back_take |=> $stable(back_fill), "fill moved idle")
    // never more than two words buffered per lane
    `SBDE_ASSERT(a_fill_max, i_clk, i_rst_n, back_fill <= FILL_MAX, "fill count out of range")
    // a full queue must hold off the input
    `SBDE_ASSERT(a_full_stall, i_clk, i_rst_n, q_stat.full |-> !i_item.ready, "accept while full")
    // every item taken by the back stage shows up as a result next cycle
    `SBDE_ASSERT(a_take_result, i_clk, i_rst_n, back_take |=> o_result.valid, "result missing")

endmodule

`default_nettype wire

// ----- tb/stream_bit_deposit_expander_test.sv -----
`timescale 1ns / 1ps

module stream_bit_deposit_expander_test;
    import sbde_pkg::*;

    typedef struct packed {
        t_op              op;
        logic [63:0]      mask;
        logic [3:0][63:0] src;
    } t_expander_item;

    typedef struct packed {
        t_status          status;
        logic [3:0][63:0] lanes;
    } t_expander_result;

    localparam int unsigned HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbde_in_if  in_bus ();
    sbde_out_if out_bus ();

    stream_bit_deposit_expander DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_bus),
        .o_result (out_bus)
    );

    always #6 i_clk = ~i_clk;

    // items waiting to be offered, and results owed by the block
    t_expander_item   pending_items[$];
    t_expander_result owed_results[$];
    t_expander_item   offered_item;

    // mirror of the per-lane bit buffers and the shared fill count
    logic [63:0] lane_lo[4];
    logic [63:0] lane_hi[4];
    int unsigned lane_fill;

    // fill count as seen by the stimulus planner, updated when an item is queued, ahead of the mirror
    int unsigned plan_fill;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        hold_ready;
    logic        pressure_go;

    int unsigned mismatch_count;
    int unsigned push_count;
    int unsigned overflow_count;
    int unsigned deposit_count;
    int unsigned underflow_count;
    int unsigned result_count;

    int unsigned send_pct_tab[4] = '{0, 60, 0, 7};
    int unsigned recv_pct_tab[4] = '{0, 0, 60, 7};

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // pdep of one buffer word under the mask, lowest source bit first
    function automatic logic [63:0] scatter_bits(logic [63:0] src, logic [63:0] m);
        logic [63:0] r;
        int          k;
        r = '0;
        k = 0;
        for (int b = 0; b < 64; b++) begin
            if (m[b]) begin
                r[b] = src[k];
                k++;
            end
        end
        return r;
    endfunction

    function automatic t_expander_result expand_item(t_expander_item it);
        t_expander_result r;
        int unsigned      pc;
        r.status = ST_ACCEPTED;
        r.lanes  = '0;
        if (it.op == OP_PUSH) begin
            if (lane_fill > 64) begin
                r.status = ST_OVERFLOW;
                overflow_count++;
            end else begin
                for (int l = 0; l < 4; l++) begin
                    if (lane_fill == 0) begin
                        lane_lo[l] = it.src[l];
                        lane_hi[l] = '0;
                    end else if (lane_fill < 64) begin
                        lane_lo[l] = lane_lo[l] | (it.src[l] << lane_fill);
                        lane_hi[l] = it.src[l] >> (64 - lane_fill);
                    end else begin
                        lane_hi[l] = it.src[l];
                    end
                end
                lane_fill += 64;
                push_count++;
            end
        end else begin
            pc = $countones(it.mask);
            if (lane_fill < pc) begin
                r.status = ST_UNDERFLOW;
                underflow_count++;
            end else begin
                r.status = ST_DEPOSITED;
                for (int l = 0; l < 4; l++) begin
                    r.lanes[l] = scatter_bits(lane_lo[l], it.mask);
                    // drop the consumed bits; a zero count borrows nothing
                    if (pc >= 64) begin
                        lane_lo[l] = lane_hi[l];
                        lane_hi[l] = '0;
                    end else if (pc != 0) begin
                        lane_lo[l] = (lane_lo[l] >> pc) | (lane_hi[l] << (64 - pc));
                        lane_hi[l] = lane_hi[l] >> pc;
                    end
                end
                lane_fill -= pc;
                deposit_count++;
            end
        end
        return r;
    endfunction

    task automatic queue_item(t_op op, logic [63:0] mask, logic [3:0][63:0] src);
        t_expander_item it;
        it.op   = op;
        it.mask = mask;
        it.src  = src;
        pending_items.insert(pending_items.size(), it);
        if (op == OP_PUSH) begin
            if (plan_fill <= 64) plan_fill += 64;
        end else if ($countones(mask) <= plan_fill) begin
            plan_fill -= $countones(mask);
        end
    endtask

    function automatic logic [63:0] random_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return '0;
        if (roll < 10) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] mask_with_ones(int unsigned k);
        logic [63:0] m;
        if (k <= 32) begin
            m = '0;
            while ($countones(m) < k) m[$urandom_range(63)] = 1'b1;
        end else begin
            m = '1;
            while ($countones(m) > k) m[$urandom_range(63)] = 1'b0;
        end
        return m;
    endfunction

    // mostly legal push/deposit sequences, with refused items mixed in
    task automatic queue_random(int unsigned n);
        int unsigned      roll;
        int unsigned      pick;
        int unsigned      room;
        logic [3:0][63:0] src;
        logic [63:0]      m;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            for (int l = 0; l < 4; l++) src[l] = random_word();
            if ((plan_fill <= 64 && roll < (plan_fill == 0 ? 70 : 45)) ||
                (plan_fill > 64 && roll < 8)) begin
                queue_item(OP_PUSH, {$urandom, $urandom}, src);
            end else begin
                pick = $urandom_range(99);
                room = (plan_fill < 64) ? plan_fill : 64;
                if (pick < 8) begin
                    m = {$urandom, $urandom};
                end else if (pick < 12) begin
                    m = '0;
                end else if (pick < 20) begin
                    m = '1;
                end else if (pick < 28 && room < 64) begin
                    m = mask_with_ones($urandom_range(64, room + 1));
                end else if (pick < 36) begin
                    m = mask_with_ones(room);
                end else begin
                    m = mask_with_ones($urandom_range(room));
                end
                queue_item(OP_DEPOSIT, m, src);
            end
        end
    endtask

    // sender: predicts each accepted item, then offers the next one or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (in_bus.valid)
                owed_results.insert(owed_results.size(), expand_item(offered_item));
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_item = pending_items.pop_front();
                in_bus.valid     <= 1'b1;
                in_bus.func      <= offered_item.op;
                in_bus.mask      <= offered_item.mask;
                in_bus.src_lane0 <= offered_item.src[0];
                in_bus.src_lane1 <= offered_item.src[1];
                in_bus.src_lane2 <= offered_item.src[2];
                in_bus.src_lane3 <= offered_item.src[3];
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    task automatic check_result();
        t_expander_result want;
        logic [3:0][63:0] got_lanes;
        got_lanes = {out_bus.out_lane3, out_bus.out_lane2, out_bus.out_lane1,
                     out_bus.out_lane0};
        result_count++;
        if (owed_results.size() == 0) begin
            note_mismatch("result with nothing owed, status", 64'(out_bus.status), '0);
        end else begin
            want = owed_results.pop_front();
            if (out_bus.status !== want.status)
                note_mismatch("status", 64'(out_bus.status), 64'(want.status));
            for (int l = 0; l < 4; l++) begin
                if (got_lanes[l] !== want.lanes[l])
                    note_mismatch($sformatf("out_lane%0d", l), got_lanes[l], want.lanes[l]);
            end
        end
    endtask

    // receiver: checks each taken result, stalls at random or under a hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) check_result();
            out_bus.ready <= !hold_ready && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long output hold while the sender keeps pushing, so the block backs up
    initial begin
        hold_ready = 1'b0;
        wait (pressure_go === 1'b1);
        @(posedge i_clk);
        hold_ready <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_ready <= 1'b0;
    end

    initial begin
        #5ms;
        $display("stream_bit_deposit_expander_test NOT OK");
        $finish;
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || owed_results.size() != 0 || in_bus.valid)
            @(negedge i_clk);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.func       = OP_PUSH;
        in_bus.mask       = '0;
        in_bus.src_lane0  = '0;
        in_bus.src_lane1  = '0;
        in_bus.src_lane2  = '0;
        in_bus.src_lane3  = '0;
        out_bus.ready     = 1'b0;
        pressure_go       = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        plan_fill         = 0;
        lane_fill         = 0;
        mismatch_count    = 0;
        push_count        = 0;
        overflow_count    = 0;
        deposit_count     = 0;
        underflow_count   = 0;
        result_count      = 0;
        for (int l = 0; l < 4; l++) begin
            lane_lo[l] = '0;
            lane_hi[l] = '0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty and full edges, both refusals, shifts at 0, 61 and 64
        queue_item(OP_DEPOSIT, '0, '0);
        queue_item(OP_DEPOSIT, 64'h1, '0);
        queue_item(OP_PUSH, '0, {64'h0123_4567_89ab_cdef, 64'h0, 64'haaaa_aaaa_aaaa_aaaa,
                                 64'hffff_ffff_ffff_ffff});
        queue_item(OP_PUSH, '1, {64'hfedc_ba98_7654_3210, 64'hffff_ffff_ffff_ffff,
                                 64'hff00_ff00_ff00_ff00, 64'h5555_5555_5555_5555});
        queue_item(OP_PUSH, '0, {random_word(), random_word(), random_word(), random_word()});
        queue_item(OP_DEPOSIT, '1, '0);
        queue_item(OP_PUSH, '0, {random_word(), random_word(), random_word(), random_word()});
        queue_item(OP_DEPOSIT, 64'h1, '0);
        queue_item(OP_PUSH, '0, {random_word(), random_word(), random_word(), random_word()});
        queue_item(OP_DEPOSIT, 64'h8000_0000_0000_0001, '1);
        queue_item(OP_DEPOSIT, '1, '0);
        queue_item(OP_DEPOSIT, '1, '0);
        queue_item(OP_PUSH, '0, {random_word(), random_word(), random_word(), random_word()});
        queue_item(OP_DEPOSIT, 64'h1fff_ffff_ffff_ffff, '0);
        queue_item(OP_DEPOSIT, 64'haaaa_aaaa_aaaa_aaaa, '0);
        queue_item(OP_DEPOSIT, '0, '0);
        queue_item(OP_DEPOSIT, 64'hffff_ffff_0000_0000, '0);
        queue_item(OP_DEPOSIT, 64'h1, '0);
        queue_item(OP_PUSH, '0, '0);
        queue_item(OP_PUSH, '0, '1);
        queue_item(OP_DEPOSIT, '1, '0);
        queue_item(OP_DEPOSIT, '1, '0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  <= send_pct_tab[phase];
            recv_stall_pct <= recv_pct_tab[phase];
            queue_random(235);
            if (phase == 0) pressure_go <= 1'b1;
            wait_drained();
        end

        // room for any stray result after the last one owed
        repeat (10) @(negedge i_clk);
        if (owed_results.size() != 0)
            note_mismatch("results never delivered, count", 64'(owed_results.size()), '0);

        $display("covered %0d results: %0d pushes, %0d overflow refusals, %0d deposits,",
                 result_count, push_count, overflow_count, deposit_count);
        $display("%0d underflow refusals, across four idle/stall mixes and a %0d-cycle hold",
                 underflow_count, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("stream_bit_deposit_expander_test OK");
        end else begin
            $display("stream_bit_deposit_expander_test NOT OK");
        end
        $finish;
    end

endmodule
